@@ src/xcr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types, link codes and command codes for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcr_pkg;

   // Field widths of the request and response channels
   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT  = 2'd2;

   localparam logic [15:0] BYTE_TIMEOUT_RESET = 16'd1024;
   localparam logic [7:0]  QUIET_RESET        = 8'd60;
   localparam logic [7:0]  RETRY_LIMIT_RESET  = 8'd25;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ABORT = 2'd3;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_LINK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

   // Link control bytes
   localparam logic [BYTE_W-1:0] LINK_SOH = 8'd1;
   localparam logic [BYTE_W-1:0] LINK_EOT = 8'd4;
   localparam logic [BYTE_W-1:0] LINK_ACK = 8'd6;
   localparam logic [BYTE_W-1:0] LINK_NAK = 8'd21;
   localparam logic [BYTE_W-1:0] LINK_CAN = 8'd24;

   // At most five responses follow from one request
   localparam int MAX_RESULTS = 5;
   localparam int CNT_W       = 3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic              frame_good;
      logic              success;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]                   count;
      result_type [MAX_RESULTS-1:0]       entry;
   } bundle_type;

   function automatic result_type res_link(input logic [BYTE_W-1:0] code);
      result_type r;
      r = '{kind: KIND_LINK, value: code, frame_good: 1'b0, success: 1'b0};
      return r;
   endfunction

   function automatic result_type res_data(input logic [BYTE_W-1:0] b);
      result_type r;
      r = '{kind: KIND_DATA, value: b, frame_good: 1'b0, success: 1'b0};
      return r;
   endfunction

   function automatic result_type res_verdict(input logic good);
      result_type r;
      r = '{kind: KIND_VERDICT, value: '0, frame_good: good, success: 1'b0};
      return r;
   endfunction

   function automatic result_type res_end(input logic ok);
      result_type r;
      r = '{kind: KIND_END, value: '0, frame_good: 1'b0, success: ok};
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/xcr_req_if.sv @@
// ----------------------------------------------------------------------------
// xcr_req_if
// Request channel: command and received link byte, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcr_req_if;
   logic                            valid;
   logic                            ready;
   logic [xcr_pkg::CMD_W-1:0]       cmd;
   logic [xcr_pkg::BYTE_W-1:0]      rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ src/xcr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// xcr_rsp_if
// Response channel: link bytes, tentative data, verdicts and transfer end.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [xcr_pkg::KIND_W-1:0]      kind;
   logic [xcr_pkg::BYTE_W-1:0]      value;
   logic                            frame_good;
   logic                            success;
   logic                            last;

   modport source (output valid, output kind, output value, output frame_good,
                   output success, output last, input ready);
   modport sink   (input valid, input kind, input value, input frame_good,
                   input success, input last, output ready);
endinterface

`default_nettype wire

@@ src/xcr_core.sv @@
// ----------------------------------------------------------------------------
// xcr_core
// Protocol state, configuration registers and the per-request next-state
// logic. Produces the full response bundle of one request combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module xcr_core #(
   parameter int DATA_BYTES = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [xcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [xcr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              step_en,
   input  wire logic [xcr_pkg::CMD_W-1:0]         cmd,
   input  wire logic [xcr_pkg::BYTE_W-1:0]        rx_byte,
   output xcr_pkg::bundle_type                    bundle
);

   localparam int POS_W = $clog2(DATA_BYTES + 3);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_BYTES + 2);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_WAIT  = 3'd1;
   localparam logic [2:0] PH_FRAME = 3'd2;
   localparam logic [2:0] PH_QUIET = 3'd3;

   logic [15:0]      byte_timeout_ff;
   logic [7:0]       quiet_ff;
   logic [7:0]       retry_limit_ff;

   logic [2:0]       phase_ff,    phase_in;
   logic [7:0]       exp_blk_ff,  exp_blk_in;
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic [7:0]       blk_num_ff,  blk_num_in;
   logic [7:0]       blk_cmp_ff,  blk_cmp_in;
   logic [7:0]       sum_ff,      sum_in;
   logic             bad_ff,      bad_in;
   logic [7:0]       retry_ff,    retry_in;
   logic [15:0]      tick_ff,     tick_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_timeout_ff <= xcr_pkg::BYTE_TIMEOUT_RESET;
         quiet_ff        <= xcr_pkg::QUIET_RESET;
         retry_limit_ff  <= xcr_pkg::RETRY_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            xcr_pkg::CSR_BYTE_TIMEOUT: byte_timeout_ff <= csr_wdata;
            xcr_pkg::CSR_QUIET:        quiet_ff        <= csr_wdata[7:0];
            xcr_pkg::CSR_RETRY_LIMIT:  retry_limit_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [15:0] tick_inc;
      logic        do_slot;
      logic        slot_ok;
      logic        good;

      phase_in   = phase_ff;
      exp_blk_in = exp_blk_ff;
      pos_in     = pos_ff;
      blk_num_in = blk_num_ff;
      blk_cmp_in = blk_cmp_ff;
      sum_in     = sum_ff;
      bad_in     = bad_ff;
      retry_in   = retry_ff;
      tick_in    = tick_ff;
      bundle     = '0;
      tick_inc   = tick_ff + 16'd1;
      do_slot    = 1'b0;
      slot_ok    = 1'b0;
      good       = 1'b0;

      if (cmd == xcr_pkg::CMD_START) begin
         exp_blk_in = 8'd1;
         retry_in   = '0;
         tick_in    = '0;
         pos_in     = '0;
         bad_in     = 1'b0;
         sum_in     = '0;
         phase_in   = PH_WAIT;
         bundle.count    = 3'd1;
         bundle.entry[0] = xcr_pkg::res_link(xcr_pkg::LINK_NAK);
      end else begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (cmd == xcr_pkg::CMD_BYTE) begin
                  tick_in = '0;
                  if (rx_byte == xcr_pkg::LINK_SOH) begin
                     phase_in = PH_FRAME;
                     pos_in   = '0;
                     sum_in   = '0;
                     bad_in   = 1'b0;
                  end else if (rx_byte == xcr_pkg::LINK_EOT) begin
                     bundle.count    = 3'd2;
                     bundle.entry[0] = xcr_pkg::res_link(xcr_pkg::LINK_ACK);
                     bundle.entry[1] = xcr_pkg::res_end(1'b1);
                     phase_in        = PH_IDLE;
                  end else begin
                     bundle.count    = 3'd4;
                     bundle.entry[0] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                     bundle.entry[1] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                     bundle.entry[2] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                     bundle.entry[3] = xcr_pkg::res_end(1'b0);
                     phase_in        = PH_IDLE;
                  end
               end else if (cmd == xcr_pkg::CMD_TICK) begin
                  tick_in = tick_inc;
                  if (tick_inc >= byte_timeout_ff) begin
                     bundle.count    = 3'd4;
                     bundle.entry[0] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                     bundle.entry[1] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                     bundle.entry[2] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                     bundle.entry[3] = xcr_pkg::res_end(1'b0);
                     phase_in        = PH_IDLE;
                  end
               end else begin
                  bundle.count    = 3'd4;
                  bundle.entry[0] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                  bundle.entry[1] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                  bundle.entry[2] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                  bundle.entry[3] = xcr_pkg::res_end(1'b0);
                  phase_in        = PH_IDLE;
               end
            end
            PH_FRAME: begin
               if (cmd == xcr_pkg::CMD_BYTE) begin
                  do_slot = 1'b1;
                  slot_ok = 1'b1;
               end else if (cmd == xcr_pkg::CMD_TICK) begin
                  tick_in = tick_inc;
                  do_slot = (tick_inc >= byte_timeout_ff);
               end else begin
                  do_slot = 1'b1;
               end
            end
            PH_QUIET: begin
               if (cmd == xcr_pkg::CMD_BYTE) begin
                  tick_in = '0;
               end else if (cmd == xcr_pkg::CMD_TICK) begin
                  tick_in = tick_inc;
                  if (tick_inc >= {8'd0, quiet_ff}) begin
                     tick_in  = '0;
                     retry_in = (retry_ff != 8'hFF) ? retry_ff + 8'd1 : retry_ff;
                     bundle.entry[0] = xcr_pkg::res_link(xcr_pkg::LINK_NAK);
                     if (retry_in > retry_limit_ff) begin
                        bundle.count    = 3'd5;
                        bundle.entry[1] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                        bundle.entry[2] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                        bundle.entry[3] = xcr_pkg::res_link(xcr_pkg::LINK_CAN);
                        bundle.entry[4] = xcr_pkg::res_end(1'b0);
                        phase_in        = PH_IDLE;
                     end else begin
                        bundle.count = 3'd1;
                        phase_in     = PH_WAIT;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // one byte slot of the frame; a timeout or abort fills it as bad
         if (do_slot) begin
            tick_in = '0;
            if (!slot_ok) begin
               bad_in = 1'b1;
            end else if (pos_ff == '0) begin
               blk_num_in = rx_byte;
            end else if (pos_ff == POS_W'(1)) begin
               blk_cmp_in = rx_byte;
            end else if (pos_ff < LAST_POS) begin
               sum_in          = sum_ff + rx_byte;
               bundle.count    = 3'd1;
               bundle.entry[0] = xcr_pkg::res_data(rx_byte);
            end else if (rx_byte != sum_ff) begin
               bad_in = 1'b1;
            end

            if (pos_ff >= LAST_POS) begin
               good = !bad_in && (blk_num_ff == exp_blk_ff) && (~blk_cmp_ff == blk_num_ff);
               bundle.entry[0] = xcr_pkg::res_verdict(good);
               if (good) begin
                  bundle.count    = 3'd2;
                  bundle.entry[1] = xcr_pkg::res_link(xcr_pkg::LINK_ACK);
                  exp_blk_in      = exp_blk_ff + 8'd1;
                  phase_in        = PH_WAIT;
               end else begin
                  bundle.count = 3'd1;
                  phase_in     = PH_QUIET;
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         exp_blk_ff <= 8'd1;
         pos_ff     <= '0;
         blk_num_ff <= '0;
         blk_cmp_ff <= '0;
         sum_ff     <= '0;
         bad_ff     <= 1'b0;
         retry_ff   <= '0;
         tick_ff    <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         exp_blk_ff <= exp_blk_in;
         pos_ff     <= pos_in;
         blk_num_ff <= blk_num_in;
         blk_cmp_ff <= blk_cmp_in;
         sum_ff     <= sum_in;
         bad_ff     <= bad_in;
         retry_ff   <= retry_in;
         tick_ff    <= tick_in;
      end
   end

   // frame position never runs past the checksum slot
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("frame position beyond checksum slot");

   // a frame or quiet phase always comes from a step
   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff))
      else $error("phase moved without a step");

   // a start always produces exactly one response
   a_start_one: assert property (@(posedge clock) disable iff (reset)
      (cmd == xcr_pkg::CMD_START) |-> (bundle.count == 3'd1))
      else $error("start did not produce a single NAK");

endmodule

`default_nettype wire

@@ src/xcr_emit.sv @@
// ----------------------------------------------------------------------------
// xcr_emit
// Response register: holds one bundle and plays it out one response a cycle while rsp_chan is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module xcr_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire xcr_pkg::bundle_type  bundle,
   output logic                      can_load,
   xcr_rsp_if.source                 rsp_chan
);

   logic                                     valid_ff;
   logic [xcr_pkg::CNT_W-1:0]                count_ff;
   logic [xcr_pkg::CNT_W-1:0]                idx_ff;
   xcr_pkg::result_type [xcr_pkg::MAX_RESULTS-1:0] entry_ff;
   xcr_pkg::result_type                      cur;
   logic                                     is_last;
   logic                                     take;

   assign is_last  = (idx_ff == count_ff - xcr_pkg::CNT_W'(1));
   assign take     = valid_ff && rsp_chan.ready;
   assign can_load = !valid_ff || (take && is_last);

   always_comb begin
      cur = '0;
      for (int i = 0; i < xcr_pkg::MAX_RESULTS; i++) begin
         if (idx_ff == xcr_pkg::CNT_W'(i)) begin
            cur = entry_ff[i];
         end
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.kind       = cur.kind;
   assign rsp_chan.value      = cur.value;
   assign rsp_chan.frame_good = cur.frame_good;
   assign rsp_chan.success    = cur.success;
   assign rsp_chan.last       = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         count_ff <= bundle.count;
         idx_ff   <= '0;
      end else if (take) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + xcr_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= bundle.entry;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < count_ff) && (count_ff != '0))
      else $error("response index outside bundle");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> (bundle.count != '0) && can_load)
      else $error("bundle loaded over pending responses or empty");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && (idx_ff == '0))
      else $error("bundle load did not restart playout");

endmodule

`default_nettype wire

@@ src/xmodem_checksum_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_unit
// XMODEM receiver, 8-bit additive checksum: turns link bytes, ticks and
// start/abort commands into link replies, tentative data, verdicts and end.
// ----------------------------------------------------------------------------
// Path: the first response of a request is valid after the request passes
//   through the request register, then the response register.
// Throughput: one request per cycle while each gives at most one response and
//   rsp_chan is ready; N responses (N up to 5) hold the response register until all are taken.
// Reset: synchronous, active high, no request taken while it is high; phase
//   idle, block 1, configuration registers at 1024 / 60 / 25, nothing pending.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_checksum_receiver_unit #(
   parameter int DATA_BYTES = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   xcr_req_if.sink                                req_chan,
   xcr_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_write_en,
   input  wire logic [xcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [xcr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Request register: one request held in front of the state logic
   logic                          in_valid_ff;
   logic [xcr_pkg::CMD_W-1:0]     in_cmd_ff;
   logic [xcr_pkg::BYTE_W-1:0]    in_byte_ff;

   xcr_pkg::bundle_type           bundle;
   logic                          can_load;
   logic                          advance;
   logic                          load;

   // Advance the held request when its responses fit into the response
   // register; a request with no response advances at once.
   assign advance = in_valid_ff && ((bundle.count == '0) || can_load);
   assign load    = advance && (bundle.count != '0);

   // Take a new request whenever the request register empties this cycle;
   // refuse requests while reset is high so none is dropped.
   assign req_chan.ready = !reset && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff  <= req_chan.cmd;
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // Protocol state and per-request decision
   xcr_core #(
      .DATA_BYTES (DATA_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .step_en      (advance),
      .cmd          (in_cmd_ff),
      .rx_byte      (in_byte_ff),
      .bundle       (bundle)
   );

   // Response register: play the bundle out in order
   xcr_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .bundle   (bundle),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   // a held request is never dropped: it stays until it advances
   a_hold_req: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_cmd_ff) && $stable(in_byte_ff))
      else $error("held request lost before advancing");

   // advancing a request with responses always loads the response register
   a_adv_load: assert property (@(posedge clock) disable iff (reset)
      advance && (bundle.count != '0) |=> rsp_chan.valid)
      else $error("responses of an advanced request not presented");

   // a taken last response never comes right after reset
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last |-> !$past(reset))
      else $error("last marker right after reset");

endmodule

`default_nettype wire
